// File: rtl/tgcw_pkg.sv
package tgcw_pkg;

	typedef struct packed {
		logic       func;
		logic [7:0] key_char;
		logic [5:0] read_row;
		logic [6:0] read_col;
	} req_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [6:0] cursor_col;
		logic [5:0] cursor_row;
		logic       scrolled;
	} rsp_t;

	localparam logic FUNC_KEY  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic CFG_COLUMNS = 1'b0;
	localparam logic CFG_ROWS    = 1'b1;

	localparam logic [7:0] KEY_NEWLINE   = 8'd10;
	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] BLANK_CHAR    = 8'd32;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET    = 7'd24;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KEY,
		ST_BS_WR,
		ST_CH_WR,
		ST_ZERO_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_ROW_CLR,
		ST_GRID_DATA,
		ST_DONE
	} state_t;

endpackage

// File: rtl/text_grid_console_writer.sv
// Character-cell text console with a cursor.
// Request channel (req_valid, req_stall, req): func 0 applies key_char at the cursor
// (newline, backspace or a printable byte), func 1 reads the cell at read_row/read_col.
// Every request gives exactly one response on (rsp_valid, rsp_stall, rsp) carrying the
// cell read and the cursor after the step; scrolled marks a key that scrolled the grid.
// The grid lives in one memory of MAX_ROWS x MAX_COLS bytes with a fixed row stride.
// One request is worked on at a time: a new request is not accepted until the last
// one's response has been loaded into the output register. A read fetches the cell;
// a character is written and the next cell zeroed, or the cursor wraps; a backspace
// within the row blanks the cell before the cursor. The response is valid on the cycle
// after ST_DONE loads it, when the next request can be accepted.
// A backspace that climbs a row scans that row cell by cell until it finds a zero
// cell, or stops at the last column in use. A scroll reads and writes each cell that
// moves up ((rows in use - 1) x columns in use), then clears the new bottom row
// column by column.
// After reset the block clears the grid, one cell per cycle; req_stall stays high
// during that pass.
// A finished response waits in the output register while rsp_stall is high; the next
// request is taken meanwhile, and its response waits until the register is free.
// columns_in_use and rows_in_use are written through cfg_we/cfg_index/cfg_data.
module text_grid_console_writer #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  tgcw_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output tgcw_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [7:0]      cfg_data
);

	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int TOTAL = MAX_ROWS * MAX_COLS;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

	tgcw_pkg::state_t state_q, state_d;

	logic [7:0]    cols_cfg_q;
	logic [6:0]    rows_cfg_q;
	logic [7:0]    cols_e;
	logic [6:0]    rows_e;

	logic [CW-1:0] cur_col_q, cur_col_d;
	logic [RW-1:0] cur_row_q, cur_row_d;
	logic [AW-1:0] clr_q, clr_d;
	logic          rsp_valid_q, rsp_valid_d;
	logic          rsp_load;

	logic [7:0]    key_q, key_d;
	logic [CW-1:0] scan_q, scan_d;
	logic [RW-1:0] idx_q, idx_d;
	logic [7:0]    cell_q, cell_d;
	logic          scr_q, scr_d;
	tgcw_pkg::rsp_t rsp_q;

	logic [7:0]    grid_mem [TOTAL];
	logic [7:0]    grid_rd_q;

	logic          grid_we, grid_re;
	logic [AW-1:0] grid_waddr, grid_raddr;
	logic [7:0]    grid_wdata;

	logic          accept;
	logic          size_zero;
	logic          last_row;
	logic          scan_last;
	logic [CW-1:0] col_s;
	logic [RW-1:0] row_s;

	function automatic logic [AW-1:0] gaddr(input logic [RW-1:0] prow,
		input logic [CW-1:0] col);
		gaddr = AW'(prow) * AW'(MAX_COLS) + AW'(col);
	endfunction

	// Register values above the physical size act as the physical size.
	assign cols_e = ({1'b0, cols_cfg_q} > 9'(MAX_COLS)) ? 8'(MAX_COLS) : cols_cfg_q;
	assign rows_e = ({1'b0, rows_cfg_q} > 8'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_cfg_q;

	assign size_zero = (cols_e == 8'd0) || (rows_e == 7'd0);
	assign col_s = (9'(cur_col_q) >= 9'(cols_e)) ? CW'(cols_e - 8'd1) : cur_col_q;
	assign row_s = (8'(cur_row_q) >= 8'(rows_e)) ? RW'(rows_e - 7'd1) : cur_row_q;
	assign last_row = (8'(cur_row_q) + 8'd1) == 8'(rows_e);
	assign scan_last = (9'(scan_q) + 9'd1) == 9'(cols_e);

	assign req_stall = (state_q != tgcw_pkg::ST_IDLE);
	assign accept = req_valid && (state_q == tgcw_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cur_col_d = cur_col_q;
		cur_row_d = cur_row_q;
		clr_d = clr_q;
		key_d = key_q;
		scan_d = scan_q;
		idx_d = idx_q;
		cell_d = cell_q;
		scr_d = scr_q;
		rsp_load = 1'b0;
		grid_we = 1'b0;
		grid_re = 1'b0;
		grid_waddr = '0;
		grid_raddr = '0;
		grid_wdata = '0;

		case (state_q)
			tgcw_pkg::ST_CLEAR: begin
				grid_we = 1'b1;
				grid_waddr = clr_q;
				if (clr_q == AW'(TOTAL - 1)) begin
					state_d = tgcw_pkg::ST_IDLE;
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			tgcw_pkg::ST_IDLE: begin
				if (accept) begin
					key_d = req.key_char;
					cell_d = 8'd0;
					scr_d = 1'b0;
					if (req.func == tgcw_pkg::FUNC_READ) begin
						if ((7'(req.read_row) < rows_e) && (8'(req.read_col) < cols_e)) begin
							grid_re = 1'b1;
							grid_raddr = gaddr(RW'(req.read_row), CW'(req.read_col));
							state_d = tgcw_pkg::ST_GRID_DATA;
						end else begin
							state_d = tgcw_pkg::ST_DONE;
						end
					end else if (size_zero) begin
						state_d = tgcw_pkg::ST_DONE;
					end else begin
						// A cursor left outside a shrunken grid is pulled back in first.
						cur_col_d = col_s;
						cur_row_d = row_s;
						state_d = tgcw_pkg::ST_KEY;
					end
				end
			end
			tgcw_pkg::ST_KEY: begin
				if (key_q == tgcw_pkg::KEY_NEWLINE) begin
					cur_col_d = '0;
					if (last_row) begin
						scr_d = 1'b1;
						idx_d = '0;
						scan_d = '0;
						if (rows_e == 7'd1) begin
							state_d = tgcw_pkg::ST_ROW_CLR;
						end else begin
							state_d = tgcw_pkg::ST_SHIFT_RD;
						end
					end else begin
						cur_row_d = cur_row_q + RW'(1);
						state_d = tgcw_pkg::ST_DONE;
					end
				end else if (key_q == tgcw_pkg::KEY_BACKSPACE) begin
					if (cur_col_q != '0) begin
						cur_col_d = cur_col_q - CW'(1);
						state_d = tgcw_pkg::ST_BS_WR;
					end else if (cur_row_q != '0) begin
						cur_row_d = cur_row_q - RW'(1);
						scan_d = '0;
						state_d = tgcw_pkg::ST_SCAN_RD;
					end else begin
						state_d = tgcw_pkg::ST_DONE;
					end
				end else begin
					state_d = tgcw_pkg::ST_CH_WR;
				end
			end
			tgcw_pkg::ST_BS_WR: begin
				grid_we = 1'b1;
				grid_waddr = gaddr(cur_row_q, cur_col_q);
				grid_wdata = tgcw_pkg::BLANK_CHAR;
				state_d = tgcw_pkg::ST_DONE;
			end
			tgcw_pkg::ST_CH_WR: begin
				grid_we = 1'b1;
				grid_waddr = gaddr(cur_row_q, cur_col_q);
				grid_wdata = key_q;
				if ((9'(cur_col_q) + 9'd1) < 9'(cols_e)) begin
					cur_col_d = cur_col_q + CW'(1);
					state_d = tgcw_pkg::ST_ZERO_WR;
				end else begin
					cur_col_d = '0;
					if (last_row) begin
						scr_d = 1'b1;
						idx_d = '0;
						scan_d = '0;
						if (rows_e == 7'd1) begin
							state_d = tgcw_pkg::ST_ROW_CLR;
						end else begin
							state_d = tgcw_pkg::ST_SHIFT_RD;
						end
					end else begin
						cur_row_d = cur_row_q + RW'(1);
						state_d = tgcw_pkg::ST_DONE;
					end
				end
			end
			tgcw_pkg::ST_ZERO_WR: begin
				grid_we = 1'b1;
				grid_waddr = gaddr(cur_row_q, cur_col_q);
				grid_wdata = 8'd0;
				state_d = tgcw_pkg::ST_DONE;
			end
			tgcw_pkg::ST_SCAN_RD: begin
				grid_re = 1'b1;
				grid_raddr = gaddr(cur_row_q, scan_q);
				state_d = tgcw_pkg::ST_SCAN_CHK;
			end
			tgcw_pkg::ST_SCAN_CHK: begin
				if (grid_rd_q == 8'd0) begin
					cur_col_d = scan_q;
					state_d = tgcw_pkg::ST_DONE;
				end else if (scan_last) begin
					cur_col_d = CW'(cols_e - 8'd1);
					state_d = tgcw_pkg::ST_DONE;
				end else begin
					scan_d = scan_q + CW'(1);
					state_d = tgcw_pkg::ST_SCAN_RD;
				end
			end
			// A scroll copies only the columns in use of each row up by one; cells
			// beyond them stay where they are.
			tgcw_pkg::ST_SHIFT_RD: begin
				grid_re = 1'b1;
				grid_raddr = gaddr(idx_q + RW'(1), scan_q);
				state_d = tgcw_pkg::ST_SHIFT_WR;
			end
			tgcw_pkg::ST_SHIFT_WR: begin
				grid_we = 1'b1;
				grid_waddr = gaddr(idx_q, scan_q);
				grid_wdata = grid_rd_q;
				if (scan_last) begin
					scan_d = '0;
					if ((8'(idx_q) + 8'd2) == 8'(rows_e)) begin
						state_d = tgcw_pkg::ST_ROW_CLR;
					end else begin
						idx_d = idx_q + RW'(1);
						state_d = tgcw_pkg::ST_SHIFT_RD;
					end
				end else begin
					scan_d = scan_q + CW'(1);
					state_d = tgcw_pkg::ST_SHIFT_RD;
				end
			end
			tgcw_pkg::ST_ROW_CLR: begin
				grid_we = 1'b1;
				grid_waddr = gaddr(cur_row_q, scan_q);
				grid_wdata = 8'd0;
				if (scan_last) begin
					state_d = tgcw_pkg::ST_DONE;
				end else begin
					scan_d = scan_q + CW'(1);
				end
			end
			tgcw_pkg::ST_GRID_DATA: begin
				cell_d = grid_rd_q;
				state_d = tgcw_pkg::ST_DONE;
			end
			tgcw_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d = tgcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tgcw_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp_valid_d = rsp_load || (rsp_valid_q && rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgcw_pkg::ST_CLEAR;
			cur_col_q <= '0;
			cur_row_q <= '0;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
			cols_cfg_q <= tgcw_pkg::COLUMNS_RESET;
			rows_cfg_q <= tgcw_pkg::ROWS_RESET;
		end else begin
			state_q <= state_d;
			cur_col_q <= cur_col_d;
			cur_row_q <= cur_row_d;
			clr_q <= clr_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_we) begin
				case (cfg_index)
					tgcw_pkg::CFG_COLUMNS: cols_cfg_q <= cfg_data;
					tgcw_pkg::CFG_ROWS:    rows_cfg_q <= cfg_data[6:0];
					default:               cols_cfg_q <= cols_cfg_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		scan_q <= scan_d;
		idx_q <= idx_d;
		cell_q <= cell_d;
		scr_q <= scr_d;
		if (rsp_load) begin
			rsp_q.cell_char <= cell_q;
			rsp_q.cursor_col <= 7'(cur_col_q);
			rsp_q.cursor_row <= 6'(cur_row_q);
			rsp_q.scrolled <= scr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (grid_we) begin
			grid_mem[grid_waddr] <= grid_wdata;
		end
		if (grid_re) begin
			grid_rd_q <= grid_mem[grid_raddr];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgcw_pkg::ST_DONE && !(rsp_valid_q && rsp_stall))
		|=> (rsp_valid_q && state_q == tgcw_pkg::ST_IDLE))
		else $error("finished response was not delivered to the output register");

	a_scan_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgcw_pkg::ST_SCAN_RD || state_q == tgcw_pkg::ST_ROW_CLR)
		|-> (9'(scan_q) < 9'(cols_e)))
		else $error("row walk left the columns in use");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgcw_pkg::ST_ROW_CLR) |-> last_row)
		else $error("scroll with the cursor away from the bottom row");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgcw_pkg::ST_CLEAR) |-> (!rsp_valid_q && req_stall))
		else $error("transfer possible during the clearing pass");

endmodule

// File: sim/tb_text_grid_console_writer.sv
module tb_text_grid_console_writer;

	localparam int GRID_COLS = 128;
	localparam int GRID_ROWS = 64;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	tgcw_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	tgcw_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_index = tgcw_pkg::CFG_COLUMNS;
	logic [7:0] cfg_data = '0;

	// Predicted console state and its size registers.
	logic [7:0] screen [GRID_ROWS][GRID_COLS];
	int pred_col;
	int pred_row;
	logic [7:0] cols_reg;
	logic [6:0] rows_reg;

	tgcw_pkg::req_t queued_reqs[$];
	tgcw_pkg::rsp_t predicted_rsps[$];
	int send_gap;
	int stall_left;
	int hold_left;
	int holds_done;
	int results_checked;
	int mismatches = 0;
	int cycle_count = 0;

	text_grid_console_writer #(
		.MAX_COLS(GRID_COLS),
		.MAX_ROWS(GRID_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic int used_cols();
		return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
	endfunction

	function automatic int used_rows();
		return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
	endfunction

	function automatic int idle_length();
		int p;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Text moves up one row once the cursor has left the last row in use.
	// Only the columns in use move; the rest of each row stays put.
	function automatic logic scroll_if_past(int nrows, int ncols);
		if (pred_row < nrows)
			return 1'b0;
		for (int rr = 0; rr + 1 < nrows; rr++)
			for (int cc = 0; cc < ncols; cc++)
				screen[rr][cc] = screen[rr + 1][cc];
		for (int cc = 0; cc < ncols; cc++)
			screen[nrows - 1][cc] = 8'd0;
		pred_row = nrows - 1;
		return 1'b1;
	endfunction

	function automatic tgcw_pkg::rsp_t console_step(tgcw_pkg::req_t r);
		int ncols;
		int nrows;
		int c;
		tgcw_pkg::rsp_t o;
		ncols = used_cols();
		nrows = used_rows();
		o = '0;
		if (r.func == tgcw_pkg::FUNC_READ) begin
			if (r.read_row < nrows && r.read_col < ncols)
				o.cell_char = screen[r.read_row][r.read_col];
		end else if (ncols != 0 && nrows != 0) begin
			if (pred_col >= ncols)
				pred_col = ncols - 1;
			if (pred_row >= nrows)
				pred_row = nrows - 1;
			if (r.key_char == tgcw_pkg::KEY_NEWLINE) begin
				pred_col = 0;
				pred_row++;
				o.scrolled = scroll_if_past(nrows, ncols);
			end else if (r.key_char == tgcw_pkg::KEY_BACKSPACE) begin
				if (pred_col > 0) begin
					pred_col--;
					screen[pred_row][pred_col] = tgcw_pkg::BLANK_CHAR;
				end else if (pred_row > 0) begin
					// Climb to the first empty cell of the row above.
					pred_row--;
					c = 0;
					while (c < ncols && screen[pred_row][c] != 8'd0)
						c++;
					pred_col = (c >= ncols) ? ncols - 1 : c;
				end
			end else begin
				screen[pred_row][pred_col] = r.key_char;
				pred_col++;
				if (pred_col < ncols) begin
					screen[pred_row][pred_col] = 8'd0;
				end else begin
					pred_col = 0;
					pred_row++;
				end
				o.scrolled = scroll_if_past(nrows, ncols);
			end
		end
		o.cursor_col = 7'(pred_col);
		o.cursor_row = 6'(pred_row);
		return o;
	endfunction

	function automatic tgcw_pkg::req_t key_req(logic [7:0] k);
		tgcw_pkg::req_t r;
		r = '0;
		r.func = tgcw_pkg::FUNC_KEY;
		r.key_char = k;
		return r;
	endfunction

	function automatic tgcw_pkg::req_t read_req(logic [5:0] row, logic [6:0] col);
		tgcw_pkg::req_t r;
		r = '0;
		r.func = tgcw_pkg::FUNC_READ;
		r.read_row = row;
		r.read_col = col;
		return r;
	endfunction

	always @(posedge clk) begin : req_side
		logic taken;
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap <= 0;
			for (int rr = 0; rr < GRID_ROWS; rr++)
				for (int cc = 0; cc < GRID_COLS; cc++)
					screen[rr][cc] = 8'd0;
			pred_col = 0;
			pred_row = 0;
		end else begin
			taken = req_valid && !req_stall;
			if (taken)
				predicted_rsps.push_back(console_step(req));
			if (!req_valid || taken) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (queued_reqs.size() != 0) begin
					req <= queued_reqs.pop_front();
					req_valid <= 1'b1;
					send_gap <= idle_length();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : rsp_side
		tgcw_pkg::rsp_t want;
		int n;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			holds_done <= 0;
			results_checked <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsps.size() == 0) begin
					$error("response with nothing outstanding: %p", rsp);
					mismatches++;
				end else begin
					want = predicted_rsps.pop_front();
					if (rsp.cell_char !== want.cell_char) begin
						$error("cell_char: expected %0d, actual %0d", want.cell_char,
							rsp.cell_char);
						mismatches++;
					end
					if (rsp.cursor_col !== want.cursor_col) begin
						$error("cursor_col: expected %0d, actual %0d", want.cursor_col,
							rsp.cursor_col);
						mismatches++;
					end
					if (rsp.cursor_row !== want.cursor_row) begin
						$error("cursor_row: expected %0d, actual %0d", want.cursor_row,
							rsp.cursor_row);
						mismatches++;
					end
					if (rsp.scrolled !== want.scrolled) begin
						$error("scrolled: expected %0d, actual %0d", want.scrolled,
							rsp.scrolled);
						mismatches++;
					end
					results_checked <= results_checked + 1;
				end
			end
			// Up to twice in the run the receiver holds off long enough for requests to back up.
			if (hold_left == 0 && holds_done < 2 && results_checked >= 150 + 300 * holds_done
					&& queued_reqs.size() > 10) begin
				hold_left <= LONG_HOLD;
				holds_done <= holds_done + 1;
				rsp_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				n = idle_length();
				stall_left <= (n > 0) ? n - 1 : 0;
				rsp_stall <= (n > 0);
			end
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (queued_reqs.size() != 0 || req_valid || predicted_rsps.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_size(logic [7:0] cols, logic [6:0] rows);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= tgcw_pkg::CFG_COLUMNS;
		cfg_data <= cols;
		@(posedge clk);
		cfg_index <= tgcw_pkg::CFG_ROWS;
		cfg_data <= {1'b0, rows};
		@(posedge clk);
		cfg_we <= 1'b0;
		cols_reg = cols;
		rows_reg = rows;
		@(negedge clk);
	endtask

	// Mostly printable bytes with newlines, backspaces and reads mixed in; reads
	// favor the area in use and the first row and column just outside it.
	task automatic push_random(int count);
		tgcw_pkg::req_t r;
		int p;
		int row_top;
		int col_top;
		row_top = (used_rows() > GRID_ROWS - 1) ? GRID_ROWS - 1 : used_rows();
		col_top = (used_cols() > GRID_COLS - 1) ? GRID_COLS - 1 : used_cols();
		@(negedge clk);
		repeat (count) begin
			r.func = tgcw_pkg::FUNC_KEY;
			r.key_char = 8'($urandom);
			r.read_row = 6'($urandom);
			r.read_col = 7'($urandom);
			p = $urandom_range(99);
			if (p < 20) begin
				r.func = tgcw_pkg::FUNC_READ;
				if ($urandom_range(3) != 0) begin
					r.read_row = 6'($urandom_range(row_top));
					r.read_col = 7'($urandom_range(col_top));
				end
			end else if (p < 32) begin
				r.key_char = tgcw_pkg::KEY_NEWLINE;
			end else if (p < 50) begin
				r.key_char = tgcw_pkg::KEY_BACKSPACE;
			end
			queued_reqs.push_back(r);
		end
	endtask

	initial begin
		cols_reg = tgcw_pkg::COLUMNS_RESET;
		rows_reg = tgcw_pkg::ROWS_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// The block clears its grid after reset and stalls requests meanwhile.
		do
			@(negedge clk);
		while (!arst_n || req_stall);

		set_size(8'd4, 7'd3);
		queued_reqs.push_back(read_req(6'd0, 7'd0));
		queued_reqs.push_back(key_req(tgcw_pkg::KEY_BACKSPACE));
		queued_reqs.push_back(key_req("A"));
		queued_reqs.push_back(key_req("B"));
		queued_reqs.push_back(key_req("C"));
		queued_reqs.push_back(key_req("D"));
		// Backspace from column zero onto a row with no empty cell.
		queued_reqs.push_back(key_req(tgcw_pkg::KEY_BACKSPACE));
		queued_reqs.push_back(key_req(tgcw_pkg::KEY_NEWLINE));
		queued_reqs.push_back(key_req(8'hFF));
		queued_reqs.push_back(key_req(8'h00));
		queued_reqs.push_back(key_req(tgcw_pkg::KEY_NEWLINE));
		queued_reqs.push_back(key_req(tgcw_pkg::KEY_NEWLINE));
		queued_reqs.push_back(read_req(6'd0, 7'd0));
		queued_reqs.push_back(read_req(6'd63, 7'd127));
		queued_reqs.push_back(read_req(6'd1, 7'd4));
		queued_reqs.push_back(key_req(tgcw_pkg::KEY_BACKSPACE));
		queued_reqs.push_back(key_req("a"));
		queued_reqs.push_back(key_req("b"));
		queued_reqs.push_back(key_req("c"));
		queued_reqs.push_back(key_req("d"));
		queued_reqs.push_back(key_req("e"));
		// Shrinking the grid leaves the cursor outside it.
		set_size(8'd2, 7'd1);
		queued_reqs.push_back(key_req("Z"));
		queued_reqs.push_back(key_req(tgcw_pkg::KEY_NEWLINE));
		set_size(8'd0, 7'd1);
		queued_reqs.push_back(key_req("Q"));
		set_size(8'd3, 7'd0);
		queued_reqs.push_back(key_req(tgcw_pkg::KEY_BACKSPACE));
		queued_reqs.push_back(read_req(6'd0, 7'd0));

		set_size(8'd8, 7'd4);
		push_random(200);
		set_size(8'd1, 7'd1);
		push_random(60);
		set_size(8'd128, 7'd64);
		push_random(60);
		set_size(8'd255, 7'd127);
		push_random(40);
		set_size(8'd16, 7'd3);
		push_random(100);
		// The sender waits here until every outstanding response is back.
		wait_drained();
		push_random(100);
		set_size(8'd5, 7'd8);
		push_random(150);
		set_size(8'd0, 7'd5);
		push_random(15);
		set_size(8'd3, 7'd0);
		push_random(15);
		set_size(tgcw_pkg::COLUMNS_RESET, tgcw_pkg::ROWS_RESET);
		push_random(100);
		set_size(8'd7, 7'd2);
		push_random(110);
		wait_drained();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
rtl/tgcw_pkg.sv
rtl/text_grid_console_writer.sv
sim/tb_text_grid_console_writer.sv
